[rtl/core/assert_macros.svh]
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define DLSQ_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("dlsq check failed");

// Check that a value holds in the cycle after a condition.
`define DLSQ_ASSERT_HOLD(name, clk, rst_n, cond, sig) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
		else $error("dlsq value changed while stalled");

`endif

[rtl/core/dlsq_pkg.sv]
`default_nettype none
package dlsq_pkg;

	localparam int RESULT_LIMIT = 16;
	localparam int RC_W         = 5;

	// request codes on the input tuser
	localparam logic [2:0] REQ_ADD   = 3'd0;
	localparam logic [2:0] REQ_TAKE  = 3'd1;
	localparam logic [2:0] REQ_TICK  = 3'd2;
	localparam logic [2:0] REQ_FIND  = 3'd3;
	localparam logic [2:0] REQ_FLUSH = 3'd4;

	// result status codes
	localparam logic [1:0] STS_OK   = 2'd0;
	localparam logic [1:0] STS_FULL = 2'd1;
	localparam logic [1:0] STS_MISS = 2'd2;

	typedef enum logic [2:0] {
		OP_ADD_TIMED,
		OP_ADD_FOREVER,
		OP_TAKE,
		OP_TICK,
		OP_FIND,
		OP_FLUSH,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [15:0] task_id;
	} cmd_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INSERT,
		S_TAKE,
		S_TICK_DEC,
		S_TICK_SCAN,
		S_FIND,
		S_RELEASE,
		S_RESULT
	} state_t;

endpackage
`default_nettype wire

[rtl/core/dlsq_front.sv]
`default_nettype none
module dlsq_front #(
	parameter int TICK_WIDTH = 16
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         s_axis_tvalid,
	output logic                        s_axis_tready,
	input  wire  [31:0]                 s_axis_tdata,
	input  wire  [2:0]                  s_axis_tuser,
	output logic                        cmd_valid,
	input  wire                         cmd_ready,
	output dlsq_pkg::cmd_t              cmd,
	output logic [TICK_WIDTH-1:0]       cmd_wait
);

	dlsq_pkg::cmd_t        cls_cmd;
	logic [TICK_WIDTH-1:0] cls_wait;
	logic [15:0]           in_wait;

	dlsq_pkg::cmd_t        ent_q [2];
	logic [TICK_WIDTH-1:0] wait_q [2];
	logic                  rd_ptr_q;
	logic                  wr_ptr_q;
	logic [1:0]            cnt_q;
	logic                  push;
	logic                  pop;

	assign in_wait = s_axis_tdata[31:16];

	always_comb begin
		cls_cmd.task_id = s_axis_tdata[15:0];
		// saturate waits beyond the tick range
		if (TICK_WIDTH < 16 && (in_wait >> TICK_WIDTH) != 16'd0) begin
			cls_wait = '1;
		end else begin
			cls_wait = TICK_WIDTH'(in_wait);
		end
		unique case (s_axis_tuser)
			dlsq_pkg::REQ_ADD:   cls_cmd.op = (in_wait == 16'd0) ? dlsq_pkg::OP_ADD_FOREVER
			                                                     : dlsq_pkg::OP_ADD_TIMED;
			dlsq_pkg::REQ_TAKE:  cls_cmd.op = dlsq_pkg::OP_TAKE;
			dlsq_pkg::REQ_TICK:  cls_cmd.op = dlsq_pkg::OP_TICK;
			dlsq_pkg::REQ_FIND:  cls_cmd.op = dlsq_pkg::OP_FIND;
			dlsq_pkg::REQ_FLUSH: cls_cmd.op = dlsq_pkg::OP_FLUSH;
			default:             cls_cmd.op = dlsq_pkg::OP_NOP;
		endcase
	end

	assign s_axis_tready = (cnt_q != 2'd2);
	assign push          = s_axis_tvalid && s_axis_tready;
	assign cmd_valid     = (cnt_q != 2'd0);
	assign pop           = cmd_valid && cmd_ready;
	assign cmd           = ent_q[rd_ptr_q];
	assign cmd_wait      = wait_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop)  rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)      cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q]  <= cls_cmd;
			wait_q[wr_ptr_q] <= cls_wait;
		end
	end

endmodule
`default_nettype wire

[rtl/core/dlsq_engine.sv]
`default_nettype none
module dlsq_engine #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TICK_WIDTH  = 16
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   cmd_valid,
	output logic                  cmd_ready,
	input  dlsq_pkg::cmd_t        cmd,
	input  wire  [TICK_WIDTH-1:0] cmd_wait,
	output logic                  m_axis_tvalid,
	input  wire                   m_axis_tready,
	output logic [23:0]           m_axis_tdata,
	output logic [0:0]            m_axis_tuser,
	output logic                  m_axis_tlast
);

	localparam int IDX_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CMP_W = (CNT_W > dlsq_pkg::RC_W) ? CNT_W : dlsq_pkg::RC_W;
	localparam int RC_W  = dlsq_pkg::RC_W;
	localparam logic [RC_W-1:0] RLIM = RC_W'(dlsq_pkg::RESULT_LIMIT);

	dlsq_pkg::state_t state_q, state_d;

	// ring of entries; head at index 0, shifted toward it
	logic [15:0]           slot_task_q    [QUEUE_DEPTH];
	logic [TICK_WIDTH-1:0] slot_delta_q   [QUEUE_DEPTH];
	logic                  slot_forever_q [QUEUE_DEPTH];

	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      step_q;
	logic                  inserted_q;
	logic [TICK_WIDTH-1:0] rem_q;
	logic [15:0]           carry_task_q;
	logic [TICK_WIDTH-1:0] carry_delta_q;
	logic                  carry_forever_q;
	logic [15:0]           id_q;
	logic                  timed_q;
	logic                  hit_q;
	logic                  running_q;
	logic [RC_W-1:0]       run_q;
	logic [RC_W-1:0]       n_q;
	logic                  fin_empty_q;
	logic [15:0]           res_id_q;
	logic                  res_valid_q;
	logic [1:0]            res_status_q;

	logic                  m_valid_q;
	logic [15:0]           m_task_q;
	logic                  m_tv_q;
	logic [1:0]            m_status_q;
	logic [RC_W-1:0]       m_rc_q;
	logic                  m_empty_q;
	logic                  m_last_q;

	logic                  can_emit;
	logic                  step_last;
	logic                  step_lt_cnt;
	logic                  ins_here;
	logic                  scan_hit;
	logic [RC_W-1:0]       run_next;
	logic                  rel_last;
	logic                  cur_match;
	logic                  take_merge;
	logic [TICK_WIDTH:0]   take_sum;
	logic [TICK_WIDTH-1:0] take_delta;
	logic [TICK_WIDTH-1:0] carry_delta_in;

	logic                  shift_en;
	logic                  hd_dec;
	logic                  ovr0_en;
	logic [15:0]           push_task;
	logic [TICK_WIDTH-1:0] push_delta;
	logic                  push_forever;
	logic                  load_result;
	logic                  load_release;

	assign can_emit    = !m_valid_q || m_axis_tready;
	assign step_last   = (step_q == IDX_W'(QUEUE_DEPTH - 1));
	assign step_lt_cnt = (CNT_W'(step_q) < count_q);
	assign ins_here    = !inserted_q && ((CNT_W'(step_q) == count_q) ||
		(timed_q && (slot_forever_q[0] || rem_q <= slot_delta_q[0])));
	assign scan_hit    = running_q && step_lt_cnt && !slot_forever_q[0] &&
		(slot_delta_q[0] == '0) && (run_q != RLIM);
	assign run_next    = run_q + RC_W'(scan_hit);
	assign rel_last    = ((n_q + RC_W'(1)) == run_q);
	assign cur_match   = step_lt_cnt && (slot_task_q[0] == id_q);
	assign take_merge  = !slot_forever_q[0] && (count_q > CNT_W'(1)) && !slot_forever_q[1];
	assign take_sum    = {1'b0, slot_delta_q[1]} + {1'b0, slot_delta_q[0]};
	assign take_delta  = take_sum[TICK_WIDTH] ? '1 : take_sum[TICK_WIDTH-1:0];
	assign carry_delta_in = (timed_q && !slot_forever_q[0] && step_lt_cnt)
		? slot_delta_q[0] - rem_q : slot_delta_q[0];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dlsq_pkg::S_IDLE: begin
				if (cmd_valid) begin
					unique case (cmd.op) inside
						dlsq_pkg::OP_ADD_TIMED, dlsq_pkg::OP_ADD_FOREVER:
							state_d = (count_q == CNT_W'(QUEUE_DEPTH)) ? dlsq_pkg::S_RESULT
							                                           : dlsq_pkg::S_INSERT;
						dlsq_pkg::OP_TAKE:
							state_d = (count_q == '0) ? dlsq_pkg::S_RESULT : dlsq_pkg::S_TAKE;
						dlsq_pkg::OP_TICK:
							state_d = dlsq_pkg::S_TICK_DEC;
						dlsq_pkg::OP_FIND:
							state_d = (count_q == '0) ? dlsq_pkg::S_RESULT : dlsq_pkg::S_FIND;
						dlsq_pkg::OP_FLUSH:
							state_d = (count_q == '0) ? dlsq_pkg::S_RESULT : dlsq_pkg::S_RELEASE;
						default:
							state_d = dlsq_pkg::S_RESULT;
					endcase
				end
			end
			dlsq_pkg::S_INSERT:   if (step_last) state_d = dlsq_pkg::S_RESULT;
			dlsq_pkg::S_TAKE:     state_d = dlsq_pkg::S_RESULT;
			dlsq_pkg::S_TICK_DEC: state_d = dlsq_pkg::S_TICK_SCAN;
			dlsq_pkg::S_TICK_SCAN: begin
				if (step_last) begin
					state_d = (run_next == '0) ? dlsq_pkg::S_RESULT : dlsq_pkg::S_RELEASE;
				end
			end
			dlsq_pkg::S_FIND:     if (step_last) state_d = dlsq_pkg::S_RESULT;
			dlsq_pkg::S_RELEASE:  if (can_emit && rel_last) state_d = dlsq_pkg::S_IDLE;
			dlsq_pkg::S_RESULT:   if (can_emit) state_d = dlsq_pkg::S_IDLE;
			default:              state_d = dlsq_pkg::S_IDLE;
		endcase
	end

	// ring and output controls
	always_comb begin
		cmd_ready    = 1'b0;
		shift_en     = 1'b0;
		hd_dec       = 1'b0;
		ovr0_en      = 1'b0;
		push_task    = slot_task_q[0];
		push_delta   = slot_delta_q[0];
		push_forever = slot_forever_q[0];
		load_result  = 1'b0;
		load_release = 1'b0;
		unique case (state_q)
			dlsq_pkg::S_IDLE:      cmd_ready = 1'b1;
			dlsq_pkg::S_INSERT: begin
				shift_en = 1'b1;
				if (ins_here) begin
					push_task    = id_q;
					push_delta   = timed_q ? rem_q : '0;
					push_forever = !timed_q;
				end else if (inserted_q) begin
					push_task    = carry_task_q;
					push_delta   = carry_delta_q;
					push_forever = carry_forever_q;
				end
			end
			dlsq_pkg::S_TAKE: begin
				shift_en = 1'b1;
				ovr0_en  = take_merge;
			end
			dlsq_pkg::S_TICK_DEC:
				hd_dec = (count_q != '0) && !slot_forever_q[0] && (slot_delta_q[0] != '0);
			dlsq_pkg::S_TICK_SCAN: shift_en = 1'b1;
			dlsq_pkg::S_FIND:      shift_en = 1'b1;
			dlsq_pkg::S_RELEASE: begin
				shift_en     = can_emit;
				load_release = can_emit;
			end
			dlsq_pkg::S_RESULT:    load_result = can_emit;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= dlsq_pkg::S_IDLE;
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == dlsq_pkg::S_INSERT && step_last) count_q <= count_q + CNT_W'(1);
			if (state_q == dlsq_pkg::S_TAKE || load_release) count_q <= count_q - CNT_W'(1);
			if (load_result || load_release) m_valid_q <= 1'b1;
			else if (m_axis_tready)          m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
				slot_task_q[j]    <= slot_task_q[j+1];
				slot_forever_q[j] <= slot_forever_q[j+1];
			end
			for (int j = 1; j < QUEUE_DEPTH - 1; j++) begin
				slot_delta_q[j] <= slot_delta_q[j+1];
			end
			// on a take of two timed entries, fold the taken head's delta into the new head
			slot_delta_q[0]               <= ovr0_en ? take_delta : slot_delta_q[1];
			slot_task_q[QUEUE_DEPTH-1]    <= push_task;
			slot_delta_q[QUEUE_DEPTH-1]   <= push_delta;
			slot_forever_q[QUEUE_DEPTH-1] <= push_forever;
		end else if (hd_dec) begin
			slot_delta_q[0] <= slot_delta_q[0] - TICK_WIDTH'(1);
		end
	end

	always_ff @(posedge clk) begin
		// restart the walk before each full pass of the ring
		step_q <= (state_q == dlsq_pkg::S_IDLE || state_q == dlsq_pkg::S_TICK_DEC)
			? '0 : step_q + IDX_W'(1);
		unique case (state_q)
			dlsq_pkg::S_IDLE: begin
				inserted_q   <= 1'b0;
				hit_q        <= 1'b0;
				running_q    <= 1'b1;
				run_q        <= '0;
				n_q          <= '0;
				id_q         <= cmd.task_id;
				timed_q      <= (cmd.op == dlsq_pkg::OP_ADD_TIMED);
				rem_q        <= cmd_wait;
				res_id_q     <= '0;
				res_valid_q  <= 1'b0;
				res_status_q <= dlsq_pkg::STS_OK;
				unique case (cmd.op) inside
					dlsq_pkg::OP_ADD_TIMED, dlsq_pkg::OP_ADD_FOREVER:
						if (count_q == CNT_W'(QUEUE_DEPTH)) res_status_q <= dlsq_pkg::STS_FULL;
					dlsq_pkg::OP_TAKE, dlsq_pkg::OP_FIND:
						if (count_q == '0) res_status_q <= dlsq_pkg::STS_MISS;
					dlsq_pkg::OP_FLUSH: begin
						run_q       <= (CMP_W'(count_q) >= CMP_W'(RLIM)) ? RLIM
						                                                 : RC_W'(count_q);
						fin_empty_q <= (CMP_W'(count_q) <= CMP_W'(RLIM));
					end
					default: ;
				endcase
			end
			dlsq_pkg::S_INSERT: begin
				if (ins_here) begin
					inserted_q      <= 1'b1;
					carry_task_q    <= slot_task_q[0];
					carry_delta_q   <= carry_delta_in;
					carry_forever_q <= slot_forever_q[0];
				end else if (inserted_q) begin
					carry_task_q    <= slot_task_q[0];
					carry_delta_q   <= slot_delta_q[0];
					carry_forever_q <= slot_forever_q[0];
				end else begin
					rem_q <= rem_q - slot_delta_q[0];
				end
			end
			dlsq_pkg::S_TAKE: begin
				res_id_q    <= slot_task_q[0];
				res_valid_q <= 1'b1;
			end
			dlsq_pkg::S_TICK_SCAN: begin
				run_q     <= run_next;
				running_q <= scan_hit;
				// release stops at the first entry that is not due, or at the result limit
				if (step_last) fin_empty_q <= (CMP_W'(run_next) == CMP_W'(count_q));
			end
			dlsq_pkg::S_FIND: begin
				hit_q <= hit_q || cur_match;
				if (step_last) begin
					res_id_q     <= (hit_q || cur_match) ? id_q : 16'd0;
					res_valid_q  <= hit_q || cur_match;
					res_status_q <= (hit_q || cur_match) ? dlsq_pkg::STS_OK
					                                     : dlsq_pkg::STS_MISS;
				end
			end
			dlsq_pkg::S_RELEASE: if (can_emit) n_q <= n_q + RC_W'(1);
			default: ;
		endcase

		if (load_result) begin
			m_task_q   <= res_id_q;
			m_tv_q     <= res_valid_q;
			m_status_q <= res_status_q;
			m_rc_q     <= '0;
			m_empty_q  <= (count_q == '0);
			m_last_q   <= 1'b1;
		end else if (load_release) begin
			m_task_q   <= slot_task_q[0];
			m_tv_q     <= 1'b1;
			m_status_q <= dlsq_pkg::STS_OK;
			m_rc_q     <= rel_last ? run_q : '0;
			m_empty_q  <= fin_empty_q;
			m_last_q   <= rel_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_empty_q, m_rc_q, m_status_q, m_task_q};
	assign m_axis_tuser  = m_tv_q;
	assign m_axis_tlast  = m_last_q;

endmodule
`default_nettype wire

[rtl/core/delta_list_sleep_queue.sv]
// Delta-list sleep queue of 16-bit task ids.
// Input stream: one request per transaction; tuser carries the request code
// (add, take head, tick, find, release all), tdata the task id and the wait.
// Output stream: one or more results per request; tlast marks the final one,
// and released_count on it tells how many tasks a tick or release-all freed.
// A two-entry command queue sits behind the input, so up to two requests are
// taken while the engine works or the output stalls.
// Per request: add and find rotate the whole entry ring once (not when an add
// meets a full queue or a find an empty one); a tick rotates it once and then
// shifts out the released tasks, if any, one by one; take head shifts the ring
// by one entry; release-all shifts out the released tasks one by one.
// This follows from the single-ported shift ring.
// Reset empties the queue at once; entry contents are left as they were.
// When the receiver deasserts tready, the result register holds and the
// engine waits; the command queue keeps accepting until it is full.
`default_nettype none
module delta_list_sleep_queue #(
	parameter int QUEUE_DEPTH = 16,
	parameter int TICK_WIDTH  = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [31:0] s_axis_tdata,  // task_id[15:0], wait_ticks[31:16]
	input  wire  [2:0]  s_axis_tuser,  // req_type[2:0]
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [23:0] m_axis_tdata,  // task_id_out[15:0], status[17:16],
	                                   // released_count[22:18], queue_empty[23]
	output logic [0:0]  m_axis_tuser,  // task_valid[0]
	output logic        m_axis_tlast
);

	logic                  cmd_valid;
	logic                  cmd_ready;
	dlsq_pkg::cmd_t        cmd;
	logic [TICK_WIDTH-1:0] cmd_wait;

	dlsq_front #(
		.TICK_WIDTH(TICK_WIDTH)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.cmd_wait     (cmd_wait)
	);

	dlsq_engine #(
		.QUEUE_DEPTH(QUEUE_DEPTH),
		.TICK_WIDTH (TICK_WIDTH)
	) u_engine (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_ready    (cmd_ready),
		.cmd          (cmd),
		.cmd_wait     (cmd_wait),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule
`default_nettype wire

[rtl/core/dlsq_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module dlsq_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_axis_tvalid,
	input wire        m_axis_tready,
	input wire [23:0] m_axis_tdata,
	input wire [0:0]  m_axis_tuser,
	input wire        m_axis_tlast
);

	logic       stall;
	logic [1:0] res_status;
	logic [4:0] res_count;
	logic       res_task;

	assign stall      = m_axis_tvalid && !m_axis_tready;
	assign res_status = m_axis_tdata[17:16];
	assign res_count  = m_axis_tdata[22:18];
	assign res_task   = m_axis_tuser[0];

	`DLSQ_ASSERT_HOLD(a_stall_data, clk, arst_n, stall, m_axis_tdata)
	`DLSQ_ASSERT(a_count_on_last, clk, arst_n, m_axis_tvalid && res_count != 5'd0 |-> m_axis_tlast)
	`DLSQ_ASSERT(a_task_is_ok, clk, arst_n, m_axis_tvalid && res_task |-> res_status == dlsq_pkg::STS_OK)
	`DLSQ_ASSERT(a_full_single, clk, arst_n, m_axis_tvalid && res_status == dlsq_pkg::STS_FULL |-> m_axis_tlast && !res_task)

endmodule

bind delta_list_sleep_queue dlsq_checker u_dlsq_checker (.*);
`default_nettype wire

[tb/testbench.sv]
`timescale 1ns / 100ps
`default_nettype none
module testbench;

	localparam int DEPTH    = 16;
	localparam int WD_LIMIT = 20000;
	localparam int N_RANDOM = 290;

	typedef struct packed {
		logic [15:0] task_id;
		logic        valid;
		logic [1:0]  status;
		logic [4:0]  released;
		logic        empty;
		logic        last;
	} result_t;

	typedef struct {
		logic [2:0]  req;
		logic [15:0] task_id;
		logic [15:0] wait_ticks;
		logic        has_result;
		logic [15:0] res_task;
		logic        res_valid;
		logic [1:0]  res_status;
		logic        res_empty;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [2:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [23:0] m_axis_tdata;
	logic [0:0] m_axis_tuser;
	logic m_axis_tlast;

	delta_list_sleep_queue u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// queue mirror
	logic [15:0] q_task [DEPTH];
	logic [15:0] q_delta [DEPTH];
	logic        q_forever [DEPTH];
	int          q_count;

	result_t expected_results[$];
	int errors, n_sent, n_results, n_released;
	int send_idle_pct, recv_idle_pct;
	int idle_cycles;
	logic timed_out;

	function automatic result_t mk(logic [15:0] id, logic v, logic [1:0] st);
		result_t r;
		r.task_id = id; r.valid = v; r.status = st;
		r.released = '0; r.empty = 1'b0; r.last = 1'b0;
		return r;
	endfunction

	function automatic void pop_head();
		for (int i = 1; i < q_count; i++) begin
			q_task[i-1] = q_task[i];
			q_delta[i-1] = q_delta[i];
			q_forever[i-1] = q_forever[i];
		end
		q_count--;
	endfunction

	// work out the results of one request and advance the mirror
	function automatic void predict_queue(logic [2:0] req, logic [15:0] id, logic [15:0] wt);
		result_t res[$];
		int released;
		logic counts;
		int pos;
		logic [15:0] rem;
		logic [16:0] sum;
		logic hit;
		released = 0;
		counts = 1'b0;
		case (req)
			dlsq_pkg::REQ_ADD: begin
				if (q_count >= DEPTH) res.push_back(mk(16'd0, 1'b0, dlsq_pkg::STS_FULL));
				else begin
					rem = wt;
					pos = 0;
					if (wt == 16'd0) pos = q_count;
					else
						while (pos < q_count && !q_forever[pos] && rem > q_delta[pos]) begin
							rem -= q_delta[pos];
							pos++;
						end
					for (int i = q_count; i > pos; i--) begin
						q_task[i] = q_task[i-1];
						q_delta[i] = q_delta[i-1];
						q_forever[i] = q_forever[i-1];
					end
					q_task[pos] = id;
					q_delta[pos] = (wt == 16'd0) ? 16'd0 : rem;
					q_forever[pos] = (wt == 16'd0);
					q_count++;
					if (wt != 16'd0 && pos + 1 < q_count && !q_forever[pos+1])
						q_delta[pos+1] -= rem;
					res.push_back(mk(16'd0, 1'b0, dlsq_pkg::STS_OK));
				end
			end
			dlsq_pkg::REQ_TAKE: begin
				if (q_count == 0) res.push_back(mk(16'd0, 1'b0, dlsq_pkg::STS_MISS));
				else begin
					if (!q_forever[0] && q_count > 1 && !q_forever[1]) begin
						sum = {1'b0, q_delta[1]} + {1'b0, q_delta[0]};
						q_delta[1] = sum[16] ? 16'hFFFF : sum[15:0];
					end
					res.push_back(mk(q_task[0], 1'b1, dlsq_pkg::STS_OK));
					pop_head();
				end
			end
			dlsq_pkg::REQ_TICK: begin
				counts = 1'b1;
				if (q_count > 0 && !q_forever[0] && q_delta[0] > 16'd0) q_delta[0]--;
				while (res.size() < dlsq_pkg::RESULT_LIMIT && q_count > 0 && !q_forever[0]
						&& q_delta[0] == 16'd0) begin
					res.push_back(mk(q_task[0], 1'b1, dlsq_pkg::STS_OK));
					pop_head();
					released++;
				end
			end
			dlsq_pkg::REQ_FIND: begin
				hit = 1'b0;
				for (int i = 0; i < q_count; i++) if (q_task[i] == id) hit = 1'b1;
				res.push_back(hit ? mk(id, 1'b1, dlsq_pkg::STS_OK)
				                  : mk(16'd0, 1'b0, dlsq_pkg::STS_MISS));
			end
			dlsq_pkg::REQ_FLUSH: begin
				counts = 1'b1;
				while (res.size() < dlsq_pkg::RESULT_LIMIT && q_count > 0) begin
					res.push_back(mk(q_task[0], 1'b1, dlsq_pkg::STS_OK));
					pop_head();
					released++;
				end
			end
			default: res.push_back(mk(16'd0, 1'b0, dlsq_pkg::STS_OK));
		endcase
		if (res.size() == 0) res.push_back(mk(16'd0, 1'b0, dlsq_pkg::STS_OK));
		foreach (res[k]) res[k].empty = (q_count == 0);
		res[res.size()-1].last = 1'b1;
		if (counts) res[res.size()-1].released = released[4:0];
		foreach (res[k]) expected_results.push_back(res[k]);
	endfunction

	// tvalid stays up after a transaction until the next idle cycle or drain
	task automatic send_request(logic [2:0] req, logic [15:0] id, logic [15:0] wt);
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= req;
		s_axis_tdata <= {wt, id};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_queue(req, id, wt);
		n_sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0 && !timed_out) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	// receiver readiness
	always @(negedge clk)
		m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);

	// result check
	always @(posedge clk) begin
		result_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.task_id = m_axis_tdata[15:0];
			got.status = m_axis_tdata[17:16];
			got.released = m_axis_tdata[22:18];
			got.empty = m_axis_tdata[23];
			got.valid = m_axis_tuser[0];
			got.last = m_axis_tlast;
			n_results++;
			if (got.valid) n_released++;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t unexpected result: id=%h valid=%b status=%0d", $time,
					got.task_id, got.valid, got.status);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					errors++;
					$display("%0t mismatch: expected id=%h v=%b st=%0d rc=%0d e=%b l=%b",
						$time, want.task_id, want.valid, want.status, want.released,
						want.empty, want.last);
					$display("%0t            actual id=%h v=%b st=%0d rc=%0d e=%b l=%b",
						$time, got.task_id, got.valid, got.status, got.released,
						got.empty, got.last);
				end
			end
		end
	end

	// watchdog on stalled transactions
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else if (arst_n) idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WD_LIMIT && !timed_out) begin
			timed_out <= 1'b1;
			$display("%0t watchdog expired, %0d results outstanding", $time,
				expected_results.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// random request: mostly adds and ticks, short waits to get releases
	task automatic random_request();
		int pick;
		logic [2:0] req;
		logic [15:0] id, wt;
		pick = $urandom_range(99);
		id = (q_count > 0 && $urandom_range(1)) ? q_task[$urandom_range(q_count-1)]
			: 16'($urandom);
		case ($urandom_range(9)) inside
			0: wt = 16'($urandom);
			1: wt = 16'hFFFF;
			2, 3: wt = 16'd0;
			default: wt = 16'($urandom_range(1, 6));
		endcase
		if (pick < 40) req = dlsq_pkg::REQ_ADD;
		else if (pick < 70) req = dlsq_pkg::REQ_TICK;
		else if (pick < 80) req = dlsq_pkg::REQ_TAKE;
		else if (pick < 92) req = dlsq_pkg::REQ_FIND;
		else if (pick < 96) req = dlsq_pkg::REQ_FLUSH;
		else req = 3'($urandom_range(5, 7));
		if (req == dlsq_pkg::REQ_FIND && $urandom_range(3) == 0) id = 16'($urandom);
		send_request(req, id, wt);
	endtask

	row_t dir_rows[$];

	task automatic add_row(logic [2:0] r, logic [15:0] id, logic [15:0] wt,
			logic chk = 1'b0, logic [15:0] et = 16'd0, logic ev = 1'b0,
			logic [1:0] es = 2'd0, logic ee = 1'b0);
		row_t x;
		x.req = r; x.task_id = id; x.wait_ticks = wt; x.has_result = chk;
		x.res_task = et; x.res_valid = ev; x.res_status = es; x.res_empty = ee;
		dir_rows.push_back(x);
	endtask

	initial begin
		result_t w;
		errors = 0; n_sent = 0; n_results = 0; n_released = 0;
		idle_cycles = 0; timed_out = 1'b0;
		send_idle_pct = 0; recv_idle_pct = 0;
		q_count = 0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: expectations typed in where obvious
		add_row(dlsq_pkg::REQ_TAKE, 16'h0000, 16'd0, 1'b1, 16'd0, 1'b0, dlsq_pkg::STS_MISS, 1'b1);
		add_row(dlsq_pkg::REQ_FIND, 16'hFFFF, 16'd0, 1'b1, 16'd0, 1'b0, dlsq_pkg::STS_MISS, 1'b1);
		add_row(dlsq_pkg::REQ_TICK, 16'd0, 16'd0, 1'b1, 16'd0, 1'b0, dlsq_pkg::STS_OK, 1'b1);
		add_row(dlsq_pkg::REQ_FLUSH, 16'd0, 16'd0, 1'b1, 16'd0, 1'b0, dlsq_pkg::STS_OK, 1'b1);
		add_row(3'd7, 16'hFFFF, 16'hFFFF, 1'b1, 16'd0, 1'b0, dlsq_pkg::STS_OK, 1'b1);
		add_row(dlsq_pkg::REQ_ADD, 16'hFFFF, 16'hFFFF);
		add_row(dlsq_pkg::REQ_ADD, 16'h0001, 16'd3);
		add_row(dlsq_pkg::REQ_ADD, 16'h0002, 16'd3);
		add_row(dlsq_pkg::REQ_ADD, 16'h0003, 16'd0);
		add_row(dlsq_pkg::REQ_ADD, 16'h0004, 16'd1);
		add_row(dlsq_pkg::REQ_FIND, 16'h0003, 16'd0, 1'b1, 16'h0003, 1'b1, dlsq_pkg::STS_OK,
			1'b0);
		add_row(dlsq_pkg::REQ_TAKE, 16'd0, 16'd0, 1'b1, 16'h0004, 1'b1, dlsq_pkg::STS_OK, 1'b0);
		add_row(dlsq_pkg::REQ_TICK, 16'd0, 16'd0);
		add_row(dlsq_pkg::REQ_TICK, 16'd0, 16'd0);
		add_row(dlsq_pkg::REQ_TICK, 16'd0, 16'd0);
		add_row(dlsq_pkg::REQ_ADD, 16'hAAAA, 16'h5555);
		add_row(dlsq_pkg::REQ_TAKE, 16'd0, 16'd0);
		for (int i = 0; i < 15; i++) add_row(dlsq_pkg::REQ_ADD, 16'(16'h100 + i), 16'd1);
		add_row(dlsq_pkg::REQ_ADD, 16'h0BAD, 16'd1, 1'b1, 16'd0, 1'b0, dlsq_pkg::STS_FULL, 1'b0);
		add_row(dlsq_pkg::REQ_TICK, 16'd0, 16'd0);
		add_row(dlsq_pkg::REQ_TICK, 16'd0, 16'd0);
		add_row(dlsq_pkg::REQ_FLUSH, 16'd0, 16'd0);
		foreach (dir_rows[i]) begin
			send_request(dir_rows[i].req, dir_rows[i].task_id, dir_rows[i].wait_ticks);
			if (dir_rows[i].has_result) begin
				w = expected_results[expected_results.size()-1];
				if (w.task_id !== dir_rows[i].res_task || w.valid !== dir_rows[i].res_valid
						|| w.status !== dir_rows[i].res_status
						|| w.empty !== dir_rows[i].res_empty) begin
					errors++;
					$display("%0t table row %0d: expected id=%h st=%0d, predicted id=%h st=%0d",
						$time, i, dir_rows[i].res_task, dir_rows[i].res_status,
						w.task_id, w.status);
				end
			end
		end
		drain();

		for (int ph = 0; ph < 3; ph++) begin
			send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 72 : 0;
			recv_idle_pct = (ph == 0) ? 72 : (ph == 1) ? 12 : 0;
			for (int i = 0; i < N_RANDOM / 3; i++) random_request();
			send_idle_pct = 0;
			drain();
		end
		recv_idle_pct = 0;
		drain();

		$display("Sent %0d requests, checked %0d results, %0d of them carrying a task.",
			n_sent, n_results, n_released);
		if (errors == 0 && expected_results.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end
endmodule
`default_nettype wire

[filelist.f]
+incdir+rtl/core
rtl/core/dlsq_pkg.sv
rtl/core/dlsq_front.sv
rtl/core/dlsq_engine.sv
rtl/core/delta_list_sleep_queue.sv
rtl/core/dlsq_checker.sv
tb/testbench.sv
